FILE: rtl/core/stereo_linked_compressor_gain_unit_assert.svh
// Assertion macros for the compressor gain unit.
`ifndef STEREO_LINKED_COMPRESSOR_GAIN_UNIT_ASSERT_SVH
`define STEREO_LINKED_COMPRESSOR_GAIN_UNIT_ASSERT_SVH
`define SLC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/slcg_pkg.sv
`default_nettype none
package slcg_pkg;
  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegRatio     = 2'd1;
  localparam logic [1:0] RegAttack    = 2'd2;
  localparam logic [1:0] RegRelease   = 2'd3;
  localparam logic [16:0] UnityGain   = 17'd65536;

  typedef enum logic [2:0] {
    OpIdle, OpDetect, OpEnvMul, OpEnvDone, OpLog, OpExpMul, OpGain, OpScale
  } dp_op_e;

  typedef struct packed {
    logic load;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

  // Mitchell log2 in Q.16 (5 bit integer part).
  function automatic logic [20:0] mlog2(input logic [23:0] x);
    logic [4:0] p;
    logic [23:0] m;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) p = 5'(i);
    end
    m = x << (5'd23 - p);
    return {p, m[22:7]};
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/slcg_datapath.sv
`default_nettype none
module slcg_datapath
  import slcg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire dp_cmd_t cmd_i,
  input  wire logic signed [23:0] left_i,
  input  wire logic signed [23:0] right_i,
  input  wire logic [23:0] thr_i,
  input  wire logic [16:0] rr_i,
  input  wire logic [15:0] att_i,
  input  wire logic [15:0] rel_i,
  output logic signed [23:0] left_o,
  output logic signed [23:0] right_o,
  output logic [16:0] gain_o
);
  logic signed [23:0] l_q, r_q;
  logic [24:0] det_q;
  logic [23:0] env_q;
  logic [16:0] coef_q;
  logic [41:0] acc_q;
  logic [20:0] lg_q;
  logic [36:0] t_q;
  logic [16:0] gain_q;
  logic signed [41:0] pl_q, pr_q;
  logic [24:0] ml, mr;
  logic [16:0] rrc;

  assign ml = left_i[23] ? 25'(-$signed({left_i[23], left_i})) : {1'b0, left_i};
  assign mr = right_i[23] ? 25'(-$signed({right_i[23], right_i})) : {1'b0, right_i};
  assign rrc = (rr_i > UnityGain) ? UnityGain : rr_i;

  function automatic logic signed [23:0] sat(input logic signed [41:0] p);
    logic signed [41:0] y;
    y = (p + 42'sd32768) >>> 16;
    if (y > 42'sd8388607) return 24'sh7FFFFF;
    if (y < -42'sd8388608) return 24'sh800000;
    return y[23:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (cmd_i.op == OpEnvDone) begin
      env_q <= acc_q[39:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      l_q <= left_i;
      r_q <= right_i;
      det_q <= (ml > mr) ? ml : mr;
    end
    case (cmd_i.op)
      OpDetect: coef_q <= {1'b0, (det_q > {1'b0, env_q}) ? att_i : rel_i};
      OpEnvMul: acc_q <= 42'(coef_q * env_q) + 42'((17'd65536 - coef_q) * det_q)
                         + 42'd32768;
      OpLog: lg_q <= mlog2(env_q) - mlog2(thr_i);
      OpExpMul: t_q <= 37'((38'(lg_q) * (17'd65536 - rrc)) >> 16);
      OpGain: begin
        if (thr_i == '0 || env_q <= thr_i) gain_q <= UnityGain;
        else if (t_q[36:16] >= 21'd17) gain_q <= '0;
        else gain_q <= 17'((18'd131072 - 18'(t_q[15:0])) >> (t_q[4+16:16] + 5'd1));
      end
      OpScale: begin
        pl_q <= l_q * $signed({1'b0, gain_q});
        pr_q <= r_q * $signed({1'b0, gain_q});
      end
      default: ;
    endcase
  end

  assign left_o = sat(pl_q);
  assign right_o = sat(pr_q);
  assign gain_o = gain_q;
endmodule
`default_nettype wire

FILE: rtl/core/slcg_ctrl.sv
`default_nettype none
module slcg_ctrl
  import slcg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output dp_cmd_t cmd_o
);
  localparam logic [2:0] SIdle = 3'd0, SDet = 3'd1, SMul = 3'd2, SEnv = 3'd3,
    SLog = 3'd4, SExp = 3'd5, SGain = 3'd6, SScale = 3'd7;
  logic [2:0] state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == SIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.load = 1'b0;
    cmd_o.op = OpIdle;
    unique case (state_q)
      SIdle: if (in_valid_i && in_ready_o) begin
        cmd_o.load = 1'b1;
        state_d = SDet;
      end
      SDet: begin cmd_o.op = OpDetect; state_d = SMul; end
      SMul: begin cmd_o.op = OpEnvMul; state_d = SEnv; end
      SEnv: begin cmd_o.op = OpEnvDone; state_d = SLog; end
      SLog: begin cmd_o.op = OpLog; state_d = SExp; end
      SExp: begin cmd_o.op = OpExpMul; state_d = SGain; end
      SGain: begin cmd_o.op = OpGain; state_d = SScale; end
      SScale: begin cmd_o.op = OpScale; state_d = SIdle; out_valid_d = 1'b1; end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/stereo_linked_compressor_gain_unit.sv
`default_nettype none
// Stereo-linked peak compressor gain stage. A request carries one stereo pair of
// Q1.23 samples; the unit tracks a one-pole envelope of the larger magnitude,
// derives a Q1.16 gain from Mitchell log2 arithmetic and returns both samples
// scaled and saturated together with the gain. Each request is processed by the
// seven-step controller sequence, from detect to scale, before its result is valid,
// and the next request is taken in the cycle after the result has been delivered,
// so pairs never overlap in the unit. Configuration writes apply at
// once and must only be made while the unit is idle.
`include "stereo_linked_compressor_gain_unit_assert.svh"
module stereo_linked_compressor_gain_unit
  import slcg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic signed [23:0] sample_left_i,
  input  wire logic signed [23:0] sample_right_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic signed [23:0] out_left_o,
  output logic signed [23:0] out_right_o,
  output logic [16:0] applied_gain_o,
  input  wire logic cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  logic [23:0] thr_q;
  logic [16:0] rr_q;
  logic [15:0] att_q, rel_q;
  dp_cmd_t cmd;

  // Configuration registers load directly from the write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 24'd2652703;
      rr_q <= 17'd32768;
      att_q <= 16'd65400;
      rel_q <= 16'd65522;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegThreshold: thr_q <= cfg_data_i;
        RegRatio: rr_q <= cfg_data_i[16:0];
        RegAttack: att_q <= cfg_data_i[15:0];
        RegRelease: rel_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  slcg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  slcg_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .left_i(sample_left_i), .right_i(sample_right_i),
    .thr_i(thr_q), .rr_i(rr_q), .att_i(att_q), .rel_i(rel_q),
    .left_o(out_left_o), .right_o(out_right_o), .gain_o(applied_gain_o)
  );

  // A result never carries a gain above unity.
  `SLC_ASSERT_IMPL(a_gain_max, out_valid_o, applied_gain_o <= UnityGain, "gain above unity")
  // No request is taken while a result is pending.
  `SLC_ASSERT_IMPL(a_no_overlap, out_valid_o, !in_ready_o, "ready while result pending")
  // An accepted request leaves the unit busy in the next cycle.
  `SLC_ASSERT_NEXT(a_busy, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o,
    "unit not busy after accept")
endmodule
`default_nettype wire
